// File: rtl/lai_pkg.sv
// Shared constants for the lead-aim intercept solver.
`default_nettype none
package lai_pkg;

	// Parameter defaults
	localparam int POSITION_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF      = 14;

	// Fixed field widths
	localparam int SPEED_W = 24;
	localparam int VEL_W   = 24;
	localparam int AIM_W   = 16;
	localparam int PATH_W  = 2;
	localparam int RES_W   = 3 * AIM_W + PATH_W;

	// Width of the exact solver arithmetic
	localparam int WIDE_W = 128;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd512000;

	// |A| below this is treated as a vanishing quadratic term
	localparam int NEAR_ZERO_A = 7;

	// Path codes
	localparam logic [PATH_W-1:0] PATH_QUAD   = 2'd0;
	localparam logic [PATH_W-1:0] PATH_LIN    = 2'd1;
	localparam logic [PATH_W-1:0] PATH_DIRECT = 2'd2;
	localparam logic [PATH_W-1:0] PATH_ZERO   = 2'd3;

endpackage
`default_nettype wire

// File: rtl/lai_fifo.sv
// Small first-in first-out queue of flat words.
`default_nettype none
module lai_fifo #(
	parameter int WIDTH     = 8,
	parameter int DEPTH_LOG = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int DEPTH = 1 << DEPTH_LOG;

	logic [WIDTH-1:0]     mem_q [DEPTH];
	logic [DEPTH_LOG-1:0] wr_ptr_q;
	logic [DEPTH_LOG-1:0] rd_ptr_q;
	logic [DEPTH_LOG:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full  = (count_q == (DEPTH_LOG+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/lai_front.sv
// Front stage: takes requests and forms the relative target position.
`default_nettype none
module lai_front #(
	parameter int POSITION_WIDTH = lai_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [POSITION_WIDTH-1:0]        shooter_x,
	input  wire logic [POSITION_WIDTH-1:0]        shooter_y,
	input  wire logic [POSITION_WIDTH-1:0]        shooter_z,
	input  wire logic [POSITION_WIDTH-1:0]        target_x,
	input  wire logic [POSITION_WIDTH-1:0]        target_y,
	input  wire logic [POSITION_WIDTH-1:0]        target_z,
	input  wire logic [lai_pkg::VEL_W-1:0]        target_vx,
	input  wire logic [lai_pkg::VEL_W-1:0]        target_vy,
	input  wire logic [lai_pkg::VEL_W-1:0]        target_vz,
	input  wire logic                             q_full,
	output logic                                  q_push,
	output logic [3*(POSITION_WIDTH+1)+3*lai_pkg::VEL_W-1:0] q_data
);
	localparam int RPW   = POSITION_WIDTH + 1;
	localparam int VW    = lai_pkg::VEL_W;
	localparam int PAY_W = 3 * RPW + 3 * VW;

	logic             v_s1;
	logic [PAY_W-1:0] pay_s1;
	logic [RPW-1:0]   rx;
	logic [RPW-1:0]   ry;
	logic [RPW-1:0]   rz;
	logic             take;

	// Relative position, one bit wider than the operands
	assign rx = {target_x[POSITION_WIDTH-1], target_x} - {shooter_x[POSITION_WIDTH-1], shooter_x};
	assign ry = {target_y[POSITION_WIDTH-1], target_y} - {shooter_y[POSITION_WIDTH-1], shooter_y};
	assign rz = {target_z[POSITION_WIDTH-1], target_z} - {shooter_z[POSITION_WIDTH-1], shooter_z};

	assign q_push = v_s1 && !q_full;
	assign full   = v_s1 && q_full;
	assign take   = push && !full;
	assign q_data = pay_s1;

	// Hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pay_s1 <= {target_vz, target_vy, target_vx, rz, ry, rx};
		end
	end
endmodule
`default_nettype wire

// File: rtl/lai_back.sv
// Back end: sequenced exact solver for intercept time and unit aim vector.
`default_nettype none
module lai_back #(
	parameter int POSITION_WIDTH      = lai_pkg::POSITION_WIDTH_DEF,
	parameter int DIRECTION_FRAC_BITS = lai_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lai_pkg::SPEED_W-1:0]   speed,
	input  wire logic                          in_empty,
	input  wire logic [3*(POSITION_WIDTH+1)+3*lai_pkg::VEL_W-1:0] in_data,
	output logic                               in_pop,
	input  wire logic                          out_full,
	output logic                               out_wr,
	output logic [lai_pkg::RES_W-1:0]          out_data
);
	localparam int RPW = POSITION_WIDTH + 1;
	localparam int VW  = lai_pkg::VEL_W;
	localparam int RW  = lai_pkg::WIDE_W;
	localparam int AW  = lai_pkg::AIM_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ISSUE  = 4'd1;
	localparam logic [3:0] ST_RUN    = 4'd2;
	localparam logic [3:0] ST_DONE   = 4'd3;
	localparam logic [3:0] ST_CLASS  = 4'd4;
	localparam logic [3:0] ST_DCHK   = 4'd5;
	localparam logic [3:0] ST_DSQRT  = 4'd6;
	localparam logic [3:0] ST_NUM    = 4'd7;
	localparam logic [3:0] ST_DIRECT = 4'd8;
	localparam logic [3:0] ST_MAG    = 4'd9;
	localparam logic [3:0] ST_SHIFT  = 4'd10;
	localparam logic [3:0] ST_NSQRT  = 4'd11;
	localparam logic [3:0] ST_NLOAD  = 4'd12;
	localparam logic [3:0] ST_DLOAD  = 4'd13;
	localparam logic [3:0] ST_DIV    = 4'd14;
	localparam logic [3:0] ST_OUT    = 4'd15;

	// Product list run through the shared multiplier
	localparam logic [4:0] OP_SS  = 5'd0;
	localparam logic [4:0] OP_VV0 = 5'd1;
	localparam logic [4:0] OP_RV0 = 5'd2;
	localparam logic [4:0] OP_RR0 = 5'd3;
	localparam logic [4:0] OP_VV1 = 5'd4;
	localparam logic [4:0] OP_RV1 = 5'd5;
	localparam logic [4:0] OP_RR1 = 5'd6;
	localparam logic [4:0] OP_VV2 = 5'd7;
	localparam logic [4:0] OP_RV2 = 5'd8;
	localparam logic [4:0] OP_RR2 = 5'd9;
	localparam logic [4:0] OP_BB  = 5'd10;
	localparam logic [4:0] OP_AC  = 5'd11;
	localparam logic [4:0] OP_RD0 = 5'd12;
	localparam logic [4:0] OP_VN0 = 5'd13;
	localparam logic [4:0] OP_RD1 = 5'd14;
	localparam logic [4:0] OP_VN1 = 5'd15;
	localparam logic [4:0] OP_RD2 = 5'd16;
	localparam logic [4:0] OP_VN2 = 5'd17;
	localparam logic [4:0] OP_SQ0 = 5'd18;
	localparam logic [4:0] OP_SQ1 = 5'd19;
	localparam logic [4:0] OP_SQ2 = 5'd20;

	function automatic logic [RW-1:0] wabs(input logic [RW-1:0] x);
		return x[RW-1] ? -x : x;
	endfunction

	function automatic logic wpos(input logic [RW-1:0] x);
		return !x[RW-1] && (x != '0);
	endfunction

	logic [3:0]              state_q;
	logic [4:0]              op_q;
	logic [RW-1:0]           r_q [3];
	logic [RW-1:0]           v_q [3];
	logic [RW-1:0]           w_q [3];
	logic [RW-1:0]           mag_q [3];
	logic [2:0]              neg_q;
	logic [AW-1:0]           aim_q [3];
	logic [RW-1:0]           a_q, b_q, c_q, d_q, num_q, den_q, m_q;
	logic [63:0]             sum_q;
	logic [lai_pkg::PATH_W-1:0] path_q;

	// Multiplier
	logic [RW-1:0]           ma_q, mb_q, acc_q;
	logic                    mneg_q;
	logic [4:0]              mc_q;
	logic [63:0]             p_s1;
	logic [2:0]              sh_s1;
	logic                    pv_s1;
	logic [RW-1:0]           opa, opb, prod;

	// Square root
	logic [RW-1:0]           sq_rad_q;
	logic [67:0]             sq_rem_q;
	logic [63:0]             sq_root_q;
	logic [5:0]              sq_cnt_q;
	logic [67:0]             sq_raw, sq_trial, sq_rem_d;
	logic                    sq_ge;

	// Divider
	logic [63:0]             dv_num_q;
	logic [31:0]             dv_rem_q;
	logic [AW-1:0]           dv_quo_q;
	logic [5:0]              dv_cnt_q;
	logic [1:0]              comp_q;
	logic [31:0]             n_q;
	logic [32:0]             dv_raw;
	logic                    dv_ge;
	logic [31:0]             dv_rem_d;
	logic [AW-1:0]           quo_d;

	// Classification terms
	logic [RW-1:0]           abs_a, bb, g, n1, n2, q_w;
	logic [RW-1:0]           mg [3];
	logic [RW-1:0]           m01, mmax;

	assign in_pop   = (state_q == ST_IDLE) && !in_empty && !out_full;
	assign out_wr   = (state_q == ST_OUT);
	assign out_data = {aim_q[0], aim_q[1], aim_q[2], path_q};

	// Select multiplier operands
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (op_q)
			OP_SS:  begin opa = RW'(speed);  opb = RW'(speed);  end
			OP_VV0: begin opa = v_q[0];      opb = v_q[0];      end
			OP_RV0: begin opa = r_q[0];      opb = v_q[0];      end
			OP_RR0: begin opa = r_q[0];      opb = r_q[0];      end
			OP_VV1: begin opa = v_q[1];      opb = v_q[1];      end
			OP_RV1: begin opa = r_q[1];      opb = v_q[1];      end
			OP_RR1: begin opa = r_q[1];      opb = r_q[1];      end
			OP_VV2: begin opa = v_q[2];      opb = v_q[2];      end
			OP_RV2: begin opa = r_q[2];      opb = v_q[2];      end
			OP_RR2: begin opa = r_q[2];      opb = r_q[2];      end
			OP_BB:  begin opa = b_q;         opb = b_q;         end
			OP_AC:  begin opa = {a_q[RW-3:0], 2'b00}; opb = c_q; end
			OP_RD0: begin opa = r_q[0];      opb = den_q;       end
			OP_VN0: begin opa = v_q[0];      opb = num_q;       end
			OP_RD1: begin opa = r_q[1];      opb = den_q;       end
			OP_VN1: begin opa = v_q[1];      opb = num_q;       end
			OP_RD2: begin opa = r_q[2];      opb = den_q;       end
			OP_VN2: begin opa = v_q[2];      opb = num_q;       end
			OP_SQ0: begin opa = mag_q[0];    opb = mag_q[0];    end
			OP_SQ1: begin opa = mag_q[1];    opb = mag_q[1];    end
			OP_SQ2: begin opa = mag_q[2];    opb = mag_q[2];    end
			default: begin opa = '0;         opb = '0;          end
		endcase
	end

	assign prod = mneg_q ? -acc_q : acc_q;

	// One root bit per step
	assign sq_raw   = {sq_rem_q[65:0], sq_rad_q[RW-1 -: 2]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_ge    = (sq_raw >= sq_trial);
	assign sq_rem_d = sq_ge ? (sq_raw - sq_trial) : sq_raw;

	// One quotient bit per step
	assign dv_raw   = {dv_rem_q, dv_num_q[63]};
	assign dv_ge    = (dv_raw >= {1'b0, n_q});
	assign dv_rem_d = dv_ge ? 32'(dv_raw - {1'b0, n_q}) : dv_raw[31:0];
	assign quo_d    = {dv_quo_q[AW-2:0], dv_ge};

	// Root choice and aim magnitudes
	assign abs_a = wabs(a_q);
	assign bb    = {b_q[RW-2:0], 1'b0};
	assign q_w   = RW'(sq_root_q);
	assign g     = a_q[RW-1] ? b_q : -b_q;
	assign n1    = g - q_w;
	assign n2    = g + q_w;
	assign mg[0] = wabs(w_q[0]);
	assign mg[1] = wabs(w_q[1]);
	assign mg[2] = wabs(w_q[2]);
	assign m01   = (mg[0] < mg[1]) ? mg[1] : mg[0];
	assign mmax  = (m01 < mg[2]) ? mg[2] : m01;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pv_s1   <= 1'b0;
		end else begin
			pv_s1 <= 1'b0;
			// Accumulate the registered partial product
			if (pv_s1) begin
				acc_q <= acc_q + (RW'(p_s1) << {sh_s1, 5'b00000});
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_pop) begin
						r_q[0] <= {{(RW-RPW){in_data[RPW-1]}}, in_data[RPW-1:0]};
						r_q[1] <= {{(RW-RPW){in_data[2*RPW-1]}}, in_data[2*RPW-1:RPW]};
						r_q[2] <= {{(RW-RPW){in_data[3*RPW-1]}}, in_data[3*RPW-1:2*RPW]};
						v_q[0] <= {{(RW-VW){in_data[3*RPW+VW-1]}},
							in_data[3*RPW+VW-1:3*RPW]};
						v_q[1] <= {{(RW-VW){in_data[3*RPW+2*VW-1]}},
							in_data[3*RPW+2*VW-1:3*RPW+VW]};
						v_q[2] <= {{(RW-VW){in_data[3*RPW+3*VW-1]}},
							in_data[3*RPW+3*VW-1:3*RPW+2*VW]};
						b_q     <= '0;
						c_q     <= '0;
						op_q    <= OP_SS;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					ma_q    <= wabs(opa);
					mb_q    <= wabs(opb);
					mneg_q  <= opa[RW-1] ^ opb[RW-1];
					acc_q   <= '0;
					mc_q    <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// Sixteen 32x32 partial products, then drain
					if (!mc_q[4]) begin
						p_s1  <= 64'(ma_q[{mc_q[1:0], 5'b00000} +: 32]) *
							64'(mb_q[{mc_q[3:2], 5'b00000} +: 32]);
						sh_s1 <= 3'(mc_q[1:0]) + 3'(mc_q[3:2]);
						pv_s1 <= 1'b1;
						mc_q  <= mc_q + 5'd1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_ISSUE;
					op_q    <= op_q + 5'd1;
					unique case (op_q)
						OP_SS: a_q <= -prod;
						OP_VV0, OP_VV1, OP_VV2: a_q <= a_q + prod;
						OP_RV0, OP_RV1, OP_RV2: b_q <= b_q + prod;
						OP_RR0, OP_RR1: c_q <= c_q + prod;
						OP_RR2: begin
							c_q     <= c_q + prod;
							state_q <= ST_CLASS;
						end
						OP_BB: d_q <= prod;
						OP_AC: begin
							d_q     <= d_q - prod;
							state_q <= ST_DCHK;
						end
						OP_RD0: w_q[0] <= prod;
						OP_RD1: w_q[1] <= prod;
						OP_RD2: w_q[2] <= prod;
						OP_VN0: w_q[0] <= w_q[0] + prod;
						OP_VN1: w_q[1] <= w_q[1] + prod;
						OP_VN2: begin
							w_q[2]  <= w_q[2] + prod;
							state_q <= ST_MAG;
						end
						OP_SQ0, OP_SQ1: sum_q <= sum_q + prod[63:0];
						OP_SQ2: begin
							sq_rad_q  <= {64'b0, sum_q + prod[63:0]};
							sq_rem_q  <= '0;
							sq_root_q <= '0;
							sq_cnt_q  <= '0;
							state_q   <= ST_NSQRT;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CLASS: begin
					// Double B, then pick linear, quadratic or direct solve
					b_q <= bb;
					if (abs_a < RW'(lai_pkg::NEAR_ZERO_A)) begin
						if (wpos(c_q) && bb[RW-1]) begin
							num_q   <= c_q;
							den_q   <= -bb;
							path_q  <= lai_pkg::PATH_LIN;
							op_q    <= OP_RD0;
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_DIRECT;
						end
					end else begin
						op_q    <= OP_BB;
						state_q <= ST_ISSUE;
					end
				end
				ST_DCHK: begin
					if (d_q[RW-1]) begin
						state_q <= ST_DIRECT;
					end else begin
						sq_rad_q  <= d_q;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						sq_cnt_q  <= '0;
						state_q   <= ST_DSQRT;
					end
				end
				ST_DSQRT, ST_NSQRT: begin
					sq_rad_q  <= {sq_rad_q[RW-3:0], 2'b00};
					sq_rem_q  <= sq_rem_d;
					sq_root_q <= {sq_root_q[62:0], sq_ge};
					sq_cnt_q  <= sq_cnt_q + 6'd1;
					if (sq_cnt_q == 6'd63) begin
						state_q <= (state_q == ST_DSQRT) ? ST_NUM : ST_NLOAD;
					end
				end
				ST_NUM: begin
					// Least positive numerator of the two roots, else direct aim
					den_q  <= abs_a + abs_a;
					path_q <= lai_pkg::PATH_QUAD;
					op_q   <= OP_RD0;
					if (wpos(n1)) begin
						num_q   <= n1;
						state_q <= ST_ISSUE;
					end else if (wpos(n2)) begin
						num_q   <= n2;
						state_q <= ST_ISSUE;
					end else begin
						state_q <= ST_DIRECT;
					end
				end
				ST_DIRECT: begin
					w_q[0]  <= r_q[0];
					w_q[1]  <= r_q[1];
					w_q[2]  <= r_q[2];
					path_q  <= lai_pkg::PATH_DIRECT;
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					mag_q[0] <= mg[0];
					mag_q[1] <= mg[1];
					mag_q[2] <= mg[2];
					neg_q    <= {w_q[2][RW-1], w_q[1][RW-1], w_q[0][RW-1]};
					m_q      <= mmax;
					if (mmax == '0) begin
						aim_q[0] <= '0;
						aim_q[1] <= '0;
						aim_q[2] <= '0;
						path_q   <= lai_pkg::PATH_ZERO;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// Drop one bit a cycle until the largest fits 31 bits
					if (m_q[RW-1:31] != '0) begin
						m_q      <= m_q >> 1;
						mag_q[0] <= mag_q[0] >> 1;
						mag_q[1] <= mag_q[1] >> 1;
						mag_q[2] <= mag_q[2] >> 1;
					end else begin
						sum_q   <= '0;
						op_q    <= OP_SQ0;
						state_q <= ST_ISSUE;
					end
				end
				ST_NLOAD: begin
					n_q     <= (sq_root_q == '0) ? 32'd1 : sq_root_q[31:0];
					comp_q  <= 2'd0;
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					dv_num_q <= (64'(mag_q[comp_q][30:0]) << DIRECTION_FRAC_BITS) +
						64'(n_q[31:1]);
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					dv_num_q <= {dv_num_q[62:0], 1'b0};
					dv_rem_q <= dv_rem_d;
					dv_quo_q <= quo_d;
					dv_cnt_q <= dv_cnt_q + 6'd1;
					if (dv_cnt_q == 6'd63) begin
						aim_q[comp_q] <= neg_q[comp_q] ? (~quo_d + 1'b1) : quo_d;
						if (comp_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/lead_aim_intercept.sv
// lead_aim_intercept: lead-aim solver with queue-style request and result ports.
// All requests run through the single sequenced solver, which forms each wide product from
//   16 partial products of 32x32, finds square roots and aim divisions one bit per step,
//   and normalises by shifting one bit at a time.
// Throughput: one request per solver pass; up to five requests queue ahead of it.
// Reset: arst_n empties the queues, idles the solver and sets the speed register to 512000.
`default_nettype none
module lead_aim_intercept #(
	parameter int POSITION_WIDTH      = lai_pkg::POSITION_WIDTH_DEF,
	parameter int DIRECTION_FRAC_BITS = lai_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [POSITION_WIDTH-1:0]     shooter_x,
	input  wire logic [POSITION_WIDTH-1:0]     shooter_y,
	input  wire logic [POSITION_WIDTH-1:0]     shooter_z,
	input  wire logic [POSITION_WIDTH-1:0]     target_x,
	input  wire logic [POSITION_WIDTH-1:0]     target_y,
	input  wire logic [POSITION_WIDTH-1:0]     target_z,
	input  wire logic [lai_pkg::VEL_W-1:0]     target_vx,
	input  wire logic [lai_pkg::VEL_W-1:0]     target_vy,
	input  wire logic [lai_pkg::VEL_W-1:0]     target_vz,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [lai_pkg::AIM_W-1:0]          aim_x,
	output logic [lai_pkg::AIM_W-1:0]          aim_y,
	output logic [lai_pkg::AIM_W-1:0]          aim_z,
	output logic [lai_pkg::PATH_W-1:0]         solve_path,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lai_pkg::SPEED_W-1:0]   projectile_speed
);
	localparam int PAY_W = 3 * (POSITION_WIDTH + 1) + 3 * lai_pkg::VEL_W;
	localparam int AW    = lai_pkg::AIM_W;

	logic [lai_pkg::SPEED_W-1:0] speed_q;
	logic                        fq_full, fq_push, fq_empty, fq_pop;
	logic [PAY_W-1:0]            fq_wdata, fq_rdata;
	logic                        rq_full, rq_wr;
	logic [lai_pkg::RES_W-1:0]   rq_wdata, rq_rdata;

	// Speed register, writable at any time the handshake completes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= lai_pkg::SPEED_RESET;
		end else if (cfg_valid) begin
			speed_q <= projectile_speed;
		end
	end

	lai_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.shooter_x(shooter_x), .shooter_y(shooter_y), .shooter_z(shooter_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.target_vx(target_vx), .target_vy(target_vy), .target_vz(target_vz),
		.q_full(fq_full), .q_push(fq_push), .q_data(fq_wdata)
	);

	lai_fifo #(.WIDTH(PAY_W), .DEPTH_LOG(2)) u_req_q (
		.clk(clk), .arst_n(arst_n), .wr(fq_push), .wdata(fq_wdata),
		.rd(fq_pop), .rdata(fq_rdata), .full(fq_full), .empty(fq_empty)
	);

	lai_back #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.DIRECTION_FRAC_BITS(DIRECTION_FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .speed(speed_q),
		.in_empty(fq_empty), .in_data(fq_rdata), .in_pop(fq_pop),
		.out_full(rq_full), .out_wr(rq_wr), .out_data(rq_wdata)
	);

	lai_fifo #(.WIDTH(lai_pkg::RES_W), .DEPTH_LOG(1)) u_res_q (
		.clk(clk), .arst_n(arst_n), .wr(rq_wr), .wdata(rq_wdata),
		.rd(pop), .rdata(rq_rdata), .full(rq_full), .empty(empty)
	);

	assign aim_x      = rq_rdata[lai_pkg::RES_W-1 -: AW];
	assign aim_y      = rq_rdata[lai_pkg::RES_W-AW-1 -: AW];
	assign aim_z      = rq_rdata[lai_pkg::PATH_W+AW-1 -: AW];
	assign solve_path = rq_rdata[lai_pkg::PATH_W-1:0];
endmodule
`default_nettype wire

// File: rtl/lai_checker.sv
// Port-level checks for the lead-aim solver, bound to the top level.
`default_nettype none
module lai_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          push,
	input wire logic                          full,
	input wire logic                          empty,
	input wire logic                          pop,
	input wire logic [lai_pkg::AIM_W-1:0]     aim_x,
	input wire logic [lai_pkg::AIM_W-1:0]     aim_y,
	input wire logic [lai_pkg::AIM_W-1:0]     aim_z,
	input wire logic [lai_pkg::PATH_W-1:0]    solve_path
);
	logic [3:0] pend_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = push && !full;
	assign acc_out = pop && !empty;

	// Track requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (acc_in && !acc_out) begin
			pend_q <= pend_q + 4'd1;
		end else if (acc_out && !acc_in) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty during reset");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result shown with no request outstanding");

	a_zero_path: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && solve_path == lai_pkg::PATH_ZERO) |->
		(aim_x == '0 && aim_y == '0 && aim_z == '0))
		else $error("zero-length path with non-zero aim");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(aim_x) && $stable(aim_y) &&
		$stable(aim_z) && $stable(solve_path)))
		else $error("waiting result changed");
endmodule

bind lead_aim_intercept lai_checker u_lai_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z), .solve_path(solve_path)
);
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the lead-aim intercept solver.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0][31:0] shooter;
		logic [2:0][31:0] target;
		logic [2:0][lai_pkg::VEL_W-1:0] vel;
	} aim_req_t;

	typedef struct packed {
		logic [lai_pkg::AIM_W-1:0] ax;
		logic [lai_pkg::AIM_W-1:0] ay;
		logic [lai_pkg::AIM_W-1:0] az;
		logic [lai_pkg::PATH_W-1:0] path;
	} aim_res_t;

	// Intercept predictor and store of expected aim results
	class aim_scoreboard;
		aim_res_t expected_aims[$];
		logic [lai_pkg::SPEED_W-1:0] speed;
		int mismatches;
		int checked;
		int path_seen[4];

		function new();
			speed = lai_pkg::SPEED_RESET;
			mismatches = 0;
			checked = 0;
			foreach (path_seen[i]) path_seen[i] = 0;
		endfunction

		function logic [63:0] root_wide(input logic [127:0] d);
			logic [63:0] res;
			logic [63:0] c;
			logic [127:0] cc;
			res = 0;
			for (int b = 63; b >= 0; b--) begin
				c = res | (64'd1 << b);
				cc = {64'd0, c} * {64'd0, c};
				if (!(d < cc)) res = c;
			end
			return res;
		endfunction

		function logic [63:0] root_narrow(input logic [63:0] d);
			logic [63:0] res;
			logic [63:0] c;
			res = 0;
			for (int b = 31; b >= 0; b--) begin
				c = res | (64'd1 << b);
				if (c * c <= d) res = c;
			end
			return res;
		endfunction

		function aim_res_t solve_intercept(input aim_req_t rq);
			logic signed [127:0] r[3], v[3], w[3];
			logic signed [127:0] a, b, c, d, abs_a, num, den, g, n1, n2, s;
			logic [127:0] mag[3], m;
			logic [63:0] red[3], sum, n, q;
			logic [1:0] path;
			aim_res_t res;
			int k;
			s = {104'd0, speed};
			for (int i = 0; i < 3; i++) begin
				r[i] = 128'(signed'(rq.target[i])) - 128'(signed'(rq.shooter[i]));
				v[i] = 128'(signed'(rq.vel[i]));
			end
			a = -(s * s);
			b = 0;
			c = 0;
			for (int i = 0; i < 3; i++) begin
				a = a + v[i] * v[i];
				b = b + r[i] * v[i];
				c = c + r[i] * r[i];
			end
			b = b + b;
			abs_a = a[127] ? -a : a;
			num = 0;
			den = 1;
			path = lai_pkg::PATH_DIRECT;
			if (abs_a < lai_pkg::NEAR_ZERO_A) begin
				// vanishing quadratic term: lead only for a positive linear time
				if (c > 0 && b < 0) begin
					num = c;
					den = -b;
					path = lai_pkg::PATH_LIN;
				end
			end else begin
				d = b * b - (a * 128'sd4) * c;
				if (!d[127]) begin
					q = root_wide(d);
					g = a[127] ? b : -b;
					n1 = g - $signed({64'd0, q});
					n2 = g + $signed({64'd0, q});
					den = abs_a + abs_a;
					if (n1 > 0) begin
						num = n1;
						path = lai_pkg::PATH_QUAD;
					end else if (n2 > 0) begin
						num = n2;
						path = lai_pkg::PATH_QUAD;
					end
				end
			end
			m = 0;
			for (int i = 0; i < 3; i++) begin
				w[i] = (path != lai_pkg::PATH_DIRECT) ? r[i] * den + v[i] * num : r[i];
				mag[i] = w[i][127] ? -w[i] : w[i];
				if (m < mag[i]) m = mag[i];
			end
			if (m == 0) begin
				res = '{ax: '0, ay: '0, az: '0, path: lai_pkg::PATH_ZERO};
				return res;
			end
			// scale down until the largest magnitude fits 31 bits
			k = 0;
			while (m >= 128'h8000_0000) begin
				m = m >> 1;
				k++;
			end
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				red[i] = 64'(mag[i] >> k);
				sum = sum + red[i] * red[i];
			end
			n = root_narrow(sum);
			if (n == 0) n = 1;
			for (int i = 0; i < 3; i++) begin
				q = ((red[i] << lai_pkg::FRAC_BITS_DEF) + (n >> 1)) / n;
				if (w[i][127]) q = -q;
				if (i == 0) res.ax = q[lai_pkg::AIM_W-1:0];
				if (i == 1) res.ay = q[lai_pkg::AIM_W-1:0];
				if (i == 2) res.az = q[lai_pkg::AIM_W-1:0];
			end
			res.path = path;
			return res;
		endfunction

		function void note_request(input aim_req_t rq);
			expected_aims.push_back(solve_intercept(rq));
		endfunction

		function void check_aim(input aim_res_t got);
			aim_res_t exp_r;
			if (expected_aims.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected aim result %h", got);
				return;
			end
			exp_r = expected_aims.pop_front();
			checked++;
			path_seen[exp_r.path]++;
			if (got.ax !== exp_r.ax || got.ay !== exp_r.ay || got.az !== exp_r.az ||
					got.path !== exp_r.path) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: aim exp x=%h y=%h z=%h path=%0d got x=%h y=%h z=%h path=%0d",
						exp_r.ax, exp_r.ay, exp_r.az, exp_r.path,
						got.ax, got.ay, got.az, got.path);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, cfg_ready;
	logic cfg_valid = 1'b0;
	logic [lai_pkg::SPEED_W-1:0] projectile_speed = lai_pkg::SPEED_RESET;
	logic [31:0] shooter_x = '0, shooter_y = '0, shooter_z = '0;
	logic [31:0] target_x = '0, target_y = '0, target_z = '0;
	logic [lai_pkg::VEL_W-1:0] target_vx = '0, target_vy = '0, target_vz = '0;
	logic [lai_pkg::AIM_W-1:0] aim_x, aim_y, aim_z;
	logic [lai_pkg::PATH_W-1:0] solve_path;

	aim_scoreboard sb = new();
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	longint cycles = 0;

	lead_aim_intercept u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.shooter_x(shooter_x), .shooter_y(shooter_y), .shooter_z(shooter_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.target_vx(target_vx), .target_vy(target_vy), .target_vz(target_vz),
		.empty(empty), .pop(pop),
		.aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z), .solve_path(solve_path),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.projectile_speed(projectile_speed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 40_000_000) begin
			$display("lead_aim_intercept verification failed");
			$finish;
		end
	end

	// Offer one request, waiting out a random gap first unless steady
	task automatic send_request(input aim_req_t rq);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		{shooter_x, shooter_y, shooter_z} <= {rq.shooter[0], rq.shooter[1], rq.shooter[2]};
		{target_x, target_y, target_z} <= {rq.target[0], rq.target[1], rq.target[2]};
		{target_vx, target_vy, target_vz} <= {rq.vel[0], rq.vel[1], rq.vel[2]};
		do @(posedge clk); while (full);
		sb.note_request(rq);
	endtask

	// Drain, let the solver settle, then write the speed register
	task automatic write_speed(input logic [lai_pkg::SPEED_W-1:0] val);
		push <= 1'b0;
		while (sb.expected_aims.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		projectile_speed <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.speed = val;
	endtask

	function automatic aim_req_t make_req(input logic [31:0] sh, input logic [31:0] tg,
			input logic [lai_pkg::VEL_W-1:0] vx);
		aim_req_t rq;
		rq.shooter = {3{sh}};
		rq.target = {3{tg}};
		rq.vel = {24'd0, 24'd0, vx};
		return rq;
	endfunction

	// Random request: mostly solvable geometry, some wide noise
	function automatic aim_req_t random_req();
		aim_req_t rq;
		int mode;
		int ax;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			rq.shooter[i] = $urandom;
			rq.target[i] = $urandom;
			rq.vel[i] = 24'($urandom);
			if (mode >= 4) begin
				rq.shooter[i] = 32'(signed'(17'($urandom)));
				rq.target[i] = 32'(signed'(17'($urandom)));
				rq.vel[i] = 24'(signed'(13'($urandom)));
			end
		end
		if (mode == 7 && sb.speed < 24'h80_0000) begin
			// target speed equals projectile speed: linear case
			ax = $urandom_range(0, 2);
			rq.vel = '0;
			rq.vel[ax] = $urandom_range(0, 1) ? sb.speed : -sb.speed;
		end
		if (mode == 8) rq.target = rq.shooter;
		if (mode == 9) rq.vel = '0;
		return rq;
	endfunction

	// Accept results with random stalls and one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 16);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (4000) @(posedge clk);
				hold_req = 1'b0;
			end else if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_aim('{ax: aim_x, ay: aim_y, az: aim_z, path: solve_path});
		end
	end

	initial begin
		logic [lai_pkg::SPEED_W-1:0] speeds[6];
		aim_req_t rq;
		arst_n <= 1'b0;
		speeds = '{lai_pkg::SPEED_RESET, 24'd0, 24'd256, 24'hFF_FFFF, 24'd0,
			lai_pkg::SPEED_RESET};
		speeds[4] = 24'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) write_speed(speeds[ph]);
			steady = (ph % 2 == 1);
			if (ph == 1) hold_req = 1'b1;
			// directed geometry for the first four speed settings
			if (ph == 0) begin
				send_request('0);
				send_request(make_req(32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF));
				send_request(make_req(32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000));
				send_request(make_req(32'd0, 32'h0000_4000, 24'd0));
				rq = make_req(32'hFFFF_0000, 32'h0001_0000, 24'h7F_FFFF);
				rq.vel = {24'h80_0000, 24'h7F_FFFF, 24'h80_0000};
				send_request(rq);
			end
			if (ph == 1) begin
				send_request(make_req(32'd0, 32'd5000, 24'd0));
				send_request(make_req(32'd0, 32'd5000, 24'd1));
				rq = make_req(32'd0, 32'd5000, 24'd0);
				rq.target = {32'd0, 32'd0, 32'd5000};
				rq.vel = {24'd0, 24'd900, 24'd0};
				send_request(rq);
				send_request(make_req(32'd0, 32'd5000, 24'd900));
			end
			if (ph == 2) begin
				send_request(make_req(32'd0, 32'd1000, 24'd256));
				send_request(make_req(32'd0, 32'd1000, -24'd256));
				send_request(make_req(32'd77, 32'd77, 24'd256));
				rq = make_req(32'd0, 32'd0, 24'd0);
				rq.target = {32'd0, 32'd0, 32'd1000};
				rq.vel = {24'd0, 24'd256, 24'd0};
				send_request(rq);
			end
			if (ph == 3) begin
				send_request(make_req(32'h8000_0000, 32'h7FFF_FFFF, 24'h7F_FFFF));
				send_request(make_req(32'd0, 32'd1, 24'd0));
			end
			repeat (290) send_request(random_req());
		end
		push <= 1'b0;
		while (sb.expected_aims.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Checked %0d aim results over six speed settings in %0d cycles",
			sb.checked, cycles);
		$display("Paths: quadratic %0d, linear %0d, direct %0d, zero-length %0d",
			sb.path_seen[0], sb.path_seen[1], sb.path_seen[2], sb.path_seen[3]);
		if (sb.mismatches == 0 && sb.expected_aims.size() == 0) begin
			$display("lead_aim_intercept verification clean");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("lead_aim_intercept verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/lai_pkg.sv
rtl/lai_fifo.sv
rtl/lai_front.sv
rtl/lai_back.sv
rtl/lead_aim_intercept.sv
rtl/lai_checker.sv
test/tb_top.sv
